FILE: src/variable_block_ring_queue_unit_macros.svh
// assertion macros for the variable block ring queue unit
// no dependencies; included by the top level
`ifndef VARIABLE_BLOCK_RING_QUEUE_UNIT_MACROS_SVH
`define VARIABLE_BLOCK_RING_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication under clock and active-low reset
`define VBRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vbrq assertion failed");

// next-cycle implication under clock and active-low reset
`define VBRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vbrq assertion failed");

`else

`define VBRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VBRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/vbrq_pkg.sv
// shared types and constants of the variable block ring queue unit
// no dependencies
`timescale 1ns / 1ps

package vbrq_pkg;

	localparam int QUEUE_BYTES        = 16384;
	localparam int MAX_PACKET         = 4096;
	localparam int HEADER_BYTES       = 16;
	localparam int BLOCK_HEADER_BYTES = 32;
	localparam int MIN_RING           = 1024;

	localparam int OFF_W  = 15;
	localparam int ADDR_W = $clog2(QUEUE_BYTES);
	localparam int LEN_W  = 15;
	localparam int CNT_W  = 10;
	localparam int ENT_W  = 16;
	localparam int PADDR_W = 3;

	typedef logic [OFF_W-1:0]  off_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ENT_W-1:0]  entry_t;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_TOO_LARGE = 3'd3;
	localparam logic [2:0] ST_SHORT     = 3'd4;

	// register index of queue_length
	localparam logic REG_QUEUE_LENGTH = 1'b0;

	// bit 15 of a store entry marks a pad block
	localparam int PAD_BIT = ENT_W - 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PUSH,
		S_POP_RD,
		S_POP_RD2
	} state_t;

	typedef struct packed {
		logic cmd;
		len_t block_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		addr_t      offset;
		len_t       out_length;
		cnt_t       count;
	} out_item_t;

	typedef struct packed {
		logic   en;
		addr_t  addr;
		entry_t data;
	} store_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} store_rd_t;

endpackage

FILE: src/vbrq_store.sv
// block length store: one write port, one registered read port
// depends on vbrq_pkg
`timescale 1ns / 1ps

module vbrq_store (
	input  logic                clk,
	input  vbrq_pkg::store_wr_t wr,
	input  vbrq_pkg::store_rd_t rd,
	output vbrq_pkg::entry_t    rd_data
);
	import vbrq_pkg::*;

	entry_t mem [QUEUE_BYTES];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/variable_block_ring_queue_unit.sv
// variable block ring queue: push/pop placement of variable-length blocks in a byte ring
// depends on vbrq_pkg, vbrq_store and variable_block_ring_queue_unit_macros.svh
// push: wrap, pad write, length and wrap-full errors settle in accept cycle; full guard in S_PUSH
// pop: result formed in S_POP_RD, or S_POP_RD2 when a pad or short remainder is skipped; reads registered
// busy until the result strobe, next transfer taken as the result leaves; one transfer in flight
// async reset: pointers to 16, count to zero, queue_length to 16384; store not cleared; no result stall
`timescale 1ns / 1ps

module variable_block_ring_queue_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  vbrq_pkg::in_item_t          item,
	// result channel
	output logic                        done,
	output vbrq_pkg::out_item_t         result,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vbrq_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import vbrq_pkg::*;

	localparam off_t HDR_OFF  = off_t'(HEADER_BYTES);
	localparam len_t MIN_LEN  = len_t'(BLOCK_HEADER_BYTES);
	localparam len_t MAX_LEN  = len_t'(MAX_PACKET);
	localparam off_t RING_LO  = off_t'(MIN_RING);
	localparam off_t RING_HI  = off_t'(QUEUE_BYTES);

	// control state
	state_t     state_q, state_d;
	off_t       head_q, head_d;
	off_t       tail_q, tail_d;
	cnt_t       count_q, count_d;
	logic [LEN_W-1:0] qlen_q;
	// item held across the sequence
	len_t       len_q, len_d;
	logic [2:0] perr_q, perr_d;
	logic       oor_q, oor_d;
	// result register
	logic       done_q;
	out_item_t  result_q, res_d;
	logic       emit;

	store_wr_t  wr;
	store_rd_t  rd;
	entry_t     rd_data;

	logic       accept;
	logic       cfg_wr;
	off_t       ring;
	logic signed [OFF_W+1:0] surplus, rest;
	logic       wrap_need;
	logic       guard_hit;
	entry_t     entry;
	len_t       pop_len;
	logic       pop_empty, pop_big, pop_skip;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;

	// apb: always ready, single register at index zero
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_QUEUE_LENGTH) begin
			prdata[LEN_W-1:0] = qlen_q;
		end
	end

	// ring size clamped to the legal range
	always_comb begin
		ring = qlen_q;
		if (qlen_q < RING_LO) begin
			ring = RING_LO;
		end else if (qlen_q > RING_HI) begin
			ring = RING_HI;
		end
	end

	// bytes left before the ring end, signed since a shrunk ring can leave pointers beyond it
	assign surplus   = $signed({2'b00, ring}) - $signed({2'b00, head_q});
	assign rest      = $signed({2'b00, ring}) - $signed({2'b00, tail_q});
	assign wrap_need = surplus < $signed({2'b00, item.block_length});

	// full guard: tail ahead of head and within len + MAX_PACKET of it
	assign guard_hit = (tail_q > head_q) &&
		({1'b0, tail_q} < ({1'b0, head_q} + {1'b0, len_q} + (OFF_W+1)'(MAX_PACKET)));

	// a read past the store depth sees zero
	assign entry     = (state_q == S_POP_RD && oor_q) ? '0 : rd_data;
	assign pop_len   = entry[LEN_W-1:0];
	assign pop_empty = (tail_q == head_q);
	assign pop_big   = (pop_len > MAX_LEN);
	assign pop_skip  = (state_q == S_POP_RD) && (head_q < tail_q) &&
		((rest < $signed((OFF_W+2)'(BLOCK_HEADER_BYTES))) || entry[PAD_BIT]);

	// datapath: pointer updates, store accesses and result
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		len_d   = len_q;
		perr_d  = perr_q;
		oor_d   = oor_q;
		wr      = '0;
		rd      = '0;
		emit    = 1'b0;
		res_d   = result_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					len_d = item.block_length;
					if (item.cmd == CMD_PUSH) begin
						// length checks, then the wrap decision on the current pointers
						perr_d = ST_OK;
						if (item.block_length < MIN_LEN) begin
							perr_d = ST_SHORT;
						end else if (item.block_length > MAX_LEN) begin
							perr_d = ST_TOO_LARGE;
						end else if (wrap_need) begin
							if (tail_q == HDR_OFF) begin
								perr_d = ST_FULL;
							end else if (tail_q > head_q) begin
								tail_d = HDR_OFF;
								head_d = HDR_OFF;
							end else if (surplus < $signed((OFF_W+2)'(BLOCK_HEADER_BYTES))) begin
								head_d = HDR_OFF;
							end else begin
								// pad block covers the remainder
								wr.en   = !head_q[OFF_W-1];
								wr.addr = head_q[ADDR_W-1:0];
								wr.data = {1'b1, surplus[LEN_W-1:0]};
								head_d  = HDR_OFF;
							end
						end
					end else begin
						rd.en   = 1'b1;
						rd.addr = tail_q[ADDR_W-1:0];
						oor_d   = tail_q[OFF_W-1];
					end
				end
			end
			S_PUSH: begin
				emit = 1'b1;
				res_d.offset     = head_q[ADDR_W-1:0];
				res_d.out_length = len_q;
				res_d.count      = count_q;
				if (perr_q != ST_OK) begin
					res_d.status = perr_q;
				end else if (guard_hit) begin
					res_d.status = ST_FULL;
				end else begin
					// record the block and advance head
					wr.en   = !head_q[OFF_W-1];
					wr.addr = head_q[ADDR_W-1:0];
					wr.data = {1'b0, len_q};
					head_d  = head_q + len_q;
					count_d = count_q + 1'b1;
					res_d.status = ST_OK;
					res_d.count  = count_d;
				end
			end
			S_POP_RD, S_POP_RD2: begin
				if (pop_skip) begin
					// skip a pad or short remainder, re-read at ring start
					tail_d  = HDR_OFF;
					rd.en   = 1'b1;
					rd.addr = HDR_OFF[ADDR_W-1:0];
					oor_d   = 1'b0;
				end else begin
					emit = 1'b1;
					res_d.offset = tail_q[ADDR_W-1:0];
					res_d.count  = count_q;
					if (pop_empty) begin
						res_d.status     = ST_EMPTY;
						res_d.out_length = '0;
					end else if (pop_big) begin
						res_d.status     = ST_TOO_LARGE;
						res_d.out_length = pop_len;
					end else begin
						tail_d  = tail_q + pop_len;
						count_d = count_q - 1'b1;
						res_d.status     = ST_OK;
						res_d.out_length = pop_len;
						res_d.count      = count_d;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (item.cmd == CMD_PUSH) ? S_PUSH : S_POP_RD;
				end
			end
			S_PUSH: begin
				state_d = S_IDLE;
			end
			S_POP_RD: begin
				state_d = pop_skip ? S_POP_RD2 : S_IDLE;
			end
			S_POP_RD2: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= HDR_OFF;
			tail_q  <= HDR_OFF;
			count_q <= '0;
			qlen_q  <= LEN_W'(QUEUE_BYTES);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			done_q  <= emit;
			if (cfg_wr && paddr[PADDR_W-1] == REG_QUEUE_LENGTH) begin
				qlen_q <= pwdata[LEN_W-1:0];
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		len_q  <= len_d;
		perr_q <= perr_d;
		oor_q  <= oor_d;
		if (emit) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	vbrq_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	`include "variable_block_ring_queue_unit_macros.svh"

	// a result strobe always comes with the unit idle again
	`VBRQ_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy)
	// an accepted transfer keeps the unit busy in the next cycle
	`VBRQ_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy)
	// an empty pop reports zero length
	`VBRQ_ASSERT_IMP(a_empty_len, clk, arst_n, done_q && result_q.status == ST_EMPTY,
		result_q.out_length == '0)

endmodule

FILE: dv/tb_variable_block_ring_queue_unit.sv
// self-checking testbench of the variable block ring queue unit
// depends on vbrq_pkg and variable_block_ring_queue_unit; scoreboard class and drive tasks inside
`timescale 1ns / 1ps

module tb_variable_block_ring_queue_unit;
	import vbrq_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 6;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_GAP         = 18;
	localparam int PHASE_ITEMS     = 160;
	localparam int PHASES          = 10;
	localparam int SWING_ITEMS     = 40;
	localparam int RANDOM_RING     = -1;
	localparam int LEN_MASK        = (1 << LEN_W) - 1;
	localparam int COUNT_MOD       = 1 << CNT_W;
	localparam int REPORT_LIMIT    = 10;
	localparam logic [PADDR_W-1:0] QLEN_ADDR = PADDR_W'(4 * REG_QUEUE_LENGTH);

	// placement predictor plus expected-result bookkeeping
	class ring_queue_scoreboard;
		int      ring_reg;
		int      head;
		int      tail;
		int      blocks;
		entry_t  length_mem [QUEUE_BYTES];
		bit      written [QUEUE_BYTES];
		out_item_t expected_outcomes[$];
		int      failures;
		int      commands;
		int      pads;
		int      status_seen [8];

		function new();
			ring_reg = QUEUE_BYTES;
			head     = HEADER_BYTES;
			tail     = HEADER_BYTES;
			blocks   = 0;
			failures = 0;
			commands = 0;
			pads     = 0;
			foreach (length_mem[i]) begin
				length_mem[i] = '0;
				written[i]    = 1'b0;
			end
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		function void set_ring(int value);
			ring_reg = value & LEN_MASK;
		endfunction

		function int ring_bytes();
			if (ring_reg < MIN_RING)
				return MIN_RING;
			if (ring_reg > QUEUE_BYTES)
				return QUEUE_BYTES;
			return ring_reg;
		endfunction

		function entry_t recall(int idx);
			if (idx >= QUEUE_BYTES)
				return '0;
			return length_mem[idx];
		endfunction

		function void remember(int idx, int value);
			if (idx < QUEUE_BYTES) begin
				length_mem[idx] = entry_t'(value);
				written[idx]    = 1'b1;
			end
		endfunction

		function bit is_defined(int idx);
			return idx < QUEUE_BYTES && written[idx];
		endfunction

		function out_item_t outcome(logic [2:0] st, int off, int len);
			out_item_t o;
			o.status     = st;
			o.offset     = addr_t'(off);
			o.out_length = len_t'(len);
			o.count      = cnt_t'(blocks);
			return o;
		endfunction

		function out_item_t place_block(int len);
			int ring;
			int surplus;
			int at;
			ring = ring_bytes();
			if (len < BLOCK_HEADER_BYTES)
				return outcome(ST_SHORT, head, len);
			if (len > MAX_PACKET)
				return outcome(ST_TOO_LARGE, head, len);
			surplus = ring - head;
			if (surplus < len) begin
				// block does not fit before the ring end
				if (tail == HEADER_BYTES)
					return outcome(ST_FULL, head, len);
				else if (tail > head) begin
					tail = HEADER_BYTES;
					head = HEADER_BYTES;
				end else if (surplus < BLOCK_HEADER_BYTES)
					head = HEADER_BYTES;
				else begin
					remember(head, (1 << PAD_BIT) | (surplus & LEN_MASK));
					pads++;
					head = HEADER_BYTES;
				end
			end
			// keep clear of the oldest block; a wrap already done stays
			if (tail > head && tail < head + len + MAX_PACKET)
				return outcome(ST_FULL, head, len);
			remember(head, len & LEN_MASK);
			at     = head;
			head   = head + len;
			blocks = (blocks + 1) % COUNT_MOD;
			return outcome(ST_OK, at, len);
		endfunction

		function out_item_t take_block();
			int     ring;
			int     len;
			int     at;
			entry_t e;
			ring = ring_bytes();
			if (head < tail) begin
				// skip a pad block or a remainder too short for a header
				e = recall(tail);
				if (ring - tail < BLOCK_HEADER_BYTES || e[PAD_BIT])
					tail = HEADER_BYTES;
			end
			if (tail == head)
				return outcome(ST_EMPTY, tail, 0);
			e   = recall(tail);
			len = e & LEN_MASK;
			if (len > MAX_PACKET)
				return outcome(ST_TOO_LARGE, tail, len);
			at     = tail;
			blocks = (blocks + COUNT_MOD - 1) % COUNT_MOD;
			tail   = tail + len;
			return outcome(ST_OK, at, len);
		endfunction

		// true when a pop now only reads store entries that hold a value
		function bit pop_reads_defined();
			int t;
			t = tail;
			if (head < t) begin
				if (ring_bytes() - t >= BLOCK_HEADER_BYTES) begin
					if (!is_defined(t))
						return 1'b0;
					if (length_mem[t][PAD_BIT])
						t = HEADER_BYTES;
				end else
					t = HEADER_BYTES;
			end
			if (t == head)
				return 1'b1;
			return is_defined(t);
		endfunction

		function void note_command(in_item_t it);
			out_item_t o;
			if (it.cmd == CMD_PUSH)
				o = place_block(int'(it.block_length));
			else
				o = take_block();
			expected_outcomes.push_back(o);
			commands++;
		endfunction

		function void note_failure(string what, int want, int got);
			if (failures < REPORT_LIMIT)
				$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
			failures++;
		endfunction

		function void check_outcome(out_item_t got);
			out_item_t want;
			if (expected_outcomes.size() == 0) begin
				note_failure("unexpected result status", -1, got.status);
				return;
			end
			want = expected_outcomes.pop_front();
			status_seen[want.status]++;
			if (got.status !== want.status)
				note_failure("status", want.status, got.status);
			if (got.offset !== want.offset)
				note_failure("offset", want.offset, got.offset);
			if (got.out_length !== want.out_length)
				note_failure("out_length", want.out_length, got.out_length);
			if (got.count !== want.count)
				note_failure("count", want.count, got.count);
		endfunction

		function int pending();
			return expected_outcomes.size();
		endfunction
	endclass

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	in_item_t            item    = '0;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [PADDR_W-1:0]  paddr   = '0;
	logic [31:0]         pwdata  = '0;
	logic                busy;
	logic                done;
	out_item_t           result;
	logic [31:0]         prdata;
	logic                pready;

	ring_queue_scoreboard sb = new();
	int                   ring_changes = 0;

	variable_block_ring_queue_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// results are sampled mid-cycle, away from the driving edge
	always @(negedge clk) begin
		if (arst_n && done)
			sb.check_outcome(result);
	end

	// one command transfer; entered and left at a rising edge
	task automatic send_command(input logic cmd, input int len, input int gap);
		in_item_t it;
		bit       taken;
		it.cmd          = cmd;
		it.block_length = len_t'(len);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		// busy seen mid-cycle decides whether the coming edge takes the item
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		sb.note_command(it);
	endtask

	// register write and read-back, only with nothing in flight
	task automatic write_ring_length(input int value);
		logic [31:0] wdata;
		logic [31:0] rdata;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		// random upper bits, only the low field is kept
		wdata   = ($urandom() & ~LEN_MASK) | (value & LEN_MASK);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= QLEN_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		sb.set_ring(value);
		ring_changes++;
		// read access straight after, psel held
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		rdata = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((rdata & LEN_MASK) !== (value & LEN_MASK))
			sb.note_failure("queue_length read-back", value & LEN_MASK, rdata & LEN_MASK);
	endtask

	// directed walk: negative length marks a pop
	int dir_list [27] = '{
		-1,                      // pop of an empty ring
		0, 31, 32767, 4097,      // short and oversized pushes
		32, 4096, -1, -1,        // smallest and largest blocks in and out
		4096, 4096, 4000, 100,   // fill, then wrap with pad and full guard hit
		-1, -1, -1, -1,          // drain, last pop skips the pad
		4096, 4096, 4096, 4000,
		100,                     // wrap with tail at ring start
		-1, -1, 70, 100,         // wrap with short remainder
		-1
	};

	int ring_settings [PHASES] = '{
		0, 32767, 16384, 2048, 1023, 16385, 16383, 1024, RANDOM_RING, RANDOM_RING
	};

	initial begin
		int  ph;
		int  n;
		int  r;
		int  len;
		int  gap;
		int  fill_pct;
		bit  calm;
		logic cmd;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part at the reset ring size
		for (n = 0; n < $size(dir_list); n++) begin
			if (dir_list[n] < 0)
				send_command(CMD_POP, $urandom_range(0, LEN_MASK), $urandom_range(0, 2));
			else
				send_command(CMD_PUSH, dir_list[n], $urandom_range(0, 2));
		end
		// shrink the ring with tail ahead of head, push wraps both pointers
		start <= 1'b0;
		write_ring_length(MIN_RING);
		send_command(CMD_PUSH, 1000, 0);
		send_command(CMD_POP, 0, 1);

		// random phases, each at its own ring size
		for (ph = 0; ph < PHASES; ph++) begin
			start <= 1'b0;
			if (ring_settings[ph] == RANDOM_RING)
				write_ring_length($urandom_range(MIN_RING, QUEUE_BYTES));
			else
				write_ring_length(ring_settings[ph]);
			fill_pct = 50;
			calm     = 1'b0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// swing between filling and draining so the ring wraps and empties
				if (n % SWING_ITEMS == 0) begin
					fill_pct = ((n / SWING_ITEMS) % 2 == 0) ? $urandom_range(60, 85)
						: $urandom_range(20, 45);
					calm = ($urandom_range(0, 3) == 0);
				end
				r = $urandom_range(0, 99);
				if (r < 6)
					len = $urandom_range(0, BLOCK_HEADER_BYTES - 1);
				else if (r < 12)
					len = $urandom_range(MAX_PACKET + 1, LEN_MASK);
				else if (r < 20)
					len = $urandom_range(MAX_PACKET - 200, MAX_PACKET);
				else if (r < 60)
					len = $urandom_range(BLOCK_HEADER_BYTES, 400);
				else
					len = $urandom_range(BLOCK_HEADER_BYTES, MAX_PACKET);
				cmd = ($urandom_range(0, 99) < fill_pct) ? CMD_PUSH : CMD_POP;
				// a pop that would read a never-written entry becomes a push
				if (cmd == CMD_POP && !sb.pop_reads_defined())
					cmd = CMD_PUSH;
				else if (cmd == CMD_POP)
					len = $urandom_range(0, LEN_MASK);
				gap = calm ? 0 : $urandom_range(0, MAX_GAP);
				send_command(cmd, len, gap);
			end
		end

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands over %0d ring sizes, %0d pad blocks placed",
			sb.commands, ring_changes, sb.pads);
		$display("outcomes: ok %0d, empty %0d, full %0d, too large %0d, short %0d",
			sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL],
			sb.status_seen[ST_TOO_LARGE], sb.status_seen[ST_SHORT]);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("variable_block_ring_queue_unit verification clean");
		else
			$display("variable_block_ring_queue_unit verification failed");
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("variable_block_ring_queue_unit verification failed");
		$finish;
	end

endmodule
